// ===== hw/rtl/lbs_pkg.sv =====
// shared constants, types and sequencing functions of the skinning block
// no dependencies; compiled first
package lbs_pkg;

  localparam int DEF_MAX_BONES  = 64;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int WORDS_PER_BONE = 12;

  localparam int WORD_W   = 32;
  localparam int BONE_W   = 6;
  localparam int ELEM_W   = 4;
  localparam int WEIGHT_W = 17;
  localparam int ACC_W    = 48;
  localparam int OUT_W    = 32;
  localparam int PROD_W   = 64;

  // weights are unsigned q1.16
  localparam int WEIGHT_FRAC = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // request kinds
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONTRIB = 1'b1;

  // first translation word of a bone
  localparam logic [ELEM_W-1:0] ELEM_T0 = ELEM_W'(9);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } lbs_state_t;

  // what a word moving down the product pipeline belongs to
  typedef struct packed {
    logic [1:0] row;
    logic       first;   // translation word, opens the row sum
    logic       lastw;   // final rotation word of the row
    logic [1:0] col;     // rotation column, selects p[col]
  } pipe_tag_t;

  // read order per row: t[row], then r[row][0..2]
  function automatic pipe_tag_t seq_tag(input logic [3:0] cnt);
    pipe_tag_t tg;
    tg.row   = cnt[3:2];
    tg.first = (cnt[1:0] == 2'd0);
    tg.lastw = (cnt[1:0] == 2'd3);
    tg.col   = cnt[1:0] - 2'd1;
    return tg;
  endfunction

  function automatic logic [ELEM_W-1:0] elem_of(input pipe_tag_t tg);
    logic [ELEM_W-1:0] row_w;
    row_w = ELEM_W'(tg.row);
    if (tg.first) begin
      return ELEM_T0 + row_w;
    end
    return (row_w << 1) + row_w + ELEM_W'(tg.col);
  endfunction

endpackage

// ===== hw/rtl/lbs_if.sv =====
// request and result channel interfaces of the skinning block
// depends on lbs_pkg
interface lbs_in_if;
  import lbs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [BONE_W-1:0]          bone;
  logic [ELEM_W-1:0]          element;
  logic signed [WORD_W-1:0]   word;
  logic signed [WORD_W-1:0]   pos_x;
  logic signed [WORD_W-1:0]   pos_y;
  logic signed [WORD_W-1:0]   pos_z;
  logic [WEIGHT_W-1:0]        weight;
  logic                       last;

  modport source (output valid, action, bone, element, word, pos_x, pos_y, pos_z,
                  weight, last, input ready);
  modport sink (input valid, action, bone, element, word, pos_x, pos_y, pos_z,
                weight, last, output ready);
endinterface

interface lbs_out_if;
  import lbs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  out_x;
  logic signed [OUT_W-1:0]  out_y;
  logic signed [OUT_W-1:0]  out_z;
  logic                     clipped;

  modport source (output valid, out_x, out_y, out_z, clipped, input ready);
  modport sink (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// ===== hw/rtl/linear_blend_skinning.sv =====
// linear blend skinning top level: transform store, product pipeline, accumulators
// depends on lbs_pkg and the lbs_in_if / lbs_out_if channel interfaces
//
// A load request writes one q16.16 transform word (rotation row-major in
// elements 0-8, translation in 9-11) into a MAX_BONES*12 word store with
// one write and one read port, leaving the block ready; loads outside the
// bone or element range are dropped. A contribution request reads the 12
// words of its bone one per cycle from the store, pushes each rotation word
// through one shared 32x32 multiplier, sums each row, clamps it, weights it
// and adds it into the x/y/z accumulators. It holds the block while the one
// store read port feeds 12 words in series and the five stage pipeline
// drains, then emits if it closes a vertex; a bone out of range skips the
// reads. A finished vertex sits in the output register while the next
// request is accepted. The store has no reset: a contribution must only
// use bones whose words were loaded since reset.
module linear_blend_skinning #(
  parameter int MAX_BONES = lbs_pkg::DEF_MAX_BONES,
  parameter int FRAC_BITS = lbs_pkg::DEF_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  lbs_in_if.sink    in_req,
  lbs_out_if.source out_res
);

  import lbs_pkg::*;

  localparam int DEPTH  = MAX_BONES * WORDS_PER_BONE;
  localparam int ADDR_W = $clog2(DEPTH);
  // one shifted product
  localparam int ADD_W  = PROD_W - FRAC_BITS;
  // three products plus translation, never narrower than a clamped row sum
  localparam int SUM_W  = (PROD_W + 3 - FRAC_BITS > ACC_W + 1) ?
                          (PROD_W + 3 - FRAC_BITS) : (ACC_W + 1);
  localparam logic [3:0] SEQ_LAST = 4'(WORDS_PER_BONE - 1);

  // transform store
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              load_we;

  // control
  lbs_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       in_fire;
  logic       bone_ok;
  logic [ADDR_W-1:0] bone_base;
  logic       busy;
  logic       out_load;

  // request held for the whole contribution
  logic signed [WORD_W-1:0] p_x_r, p_y_r, p_z_r;
  logic [WEIGHT_W-1:0]      w_r;
  logic                     last_r;
  logic [ADDR_W-1:0]        base_r;

  // product pipeline
  logic                     v1_r, v2_r, v3_r, v4_r, v5_r;
  pipe_tag_t                tag1_r, tag2_r;
  logic [1:0]               row3_r, row4_r, row5_r;
  logic signed [WORD_W-1:0] p_sel;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [ADD_W-1:0]  addend;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [ACC_W-1:0]  r_nxt, r_r;
  logic signed [PROD_W-1:0] wprod_r;
  logic signed [ACC_W-1:0]  term;

  // accumulators
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r, acc_z_r;
  logic signed [ACC_W-1:0] acc_x_nxt, acc_y_nxt, acc_z_nxt;
  logic signed [ACC_W-1:0] acc_sel, acc_upd;
  logic signed [ACC_W:0]   acc_sum;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                    clipped_r;
  logic signed [OUT_W-1:0] sat_x, sat_y, sat_z;
  logic                    clip_x, clip_y, clip_z;

  assign in_fire   = in_req.valid && in_req.ready;
  assign bone_ok   = (32'(in_req.bone) < MAX_BONES);
  // bone * 12
  assign bone_base = ADDR_W'({in_req.bone, 3'b000}) + ADDR_W'({in_req.bone, 2'b00});
  assign wr_addr   = bone_base + ADDR_W'(in_req.element);
  assign load_we   = in_fire && (in_req.action == ACT_LOAD) && bone_ok &&
                     (32'(in_req.element) < WORDS_PER_BONE);
  assign rd_addr   = base_r + ADDR_W'(elem_of(seq_tag(cnt_r)));
  assign busy      = v1_r || v2_r || v3_r || v4_r || v5_r;

  // store: writes only while idle, reads only while sequencing
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[wr_addr] <= in_req.word;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_req.ready = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_req.ready = 1'b1;
        cnt_nxt      = 4'd0;
        if (in_req.valid && in_req.action == ACT_CONTRIB) begin
          // a bone out of range adds nothing but still honors last
          state_nxt = bone_ok ? ST_RUN : ST_DRAIN;
        end
      end
      ST_RUN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == SEQ_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // capture the contribution request
  always_ff @(posedge clk) begin
    if (in_fire && in_req.action == ACT_CONTRIB) begin
      p_x_r  <= in_req.pos_x;
      p_y_r  <= in_req.pos_y;
      p_z_r  <= in_req.pos_z;
      w_r    <= (in_req.weight > WEIGHT_ONE) ? WEIGHT_ONE : in_req.weight;
      last_r <= in_req.last;
      base_r <= bone_base;
    end
  end

  // stage 1: word back from the store -> product, translation scaled up so
  // that the common floor shift returns it unchanged
  always_comb begin
    unique case (tag1_r.col)
      2'd0:    p_sel = p_x_r;
      2'd1:    p_sel = p_y_r;
      default: p_sel = p_z_r;
    endcase
    if (tag1_r.first) begin
      prod_nxt = PROD_W'(signed'(rd_data_r)) <<< FRAC_BITS;
    end else begin
      prod_nxt = PROD_W'(signed'(rd_data_r)) * PROD_W'(p_sel);
    end
  end

  // stage 2 addend, floor shift
  assign addend = ADD_W'(prod_r >>> FRAC_BITS);

  // stage 3 clamp of the finished row sum
  always_comb begin
    if (sum_r > SUM_W'(ACC_MAX)) begin
      r_nxt = ACC_MAX;
    end else if (sum_r < SUM_W'(ACC_MIN)) begin
      r_nxt = ACC_MIN;
    end else begin
      r_nxt = ACC_W'(sum_r);
    end
  end

  // stage 5 weighted term, floor of the q1.16 scaling
  assign term = wprod_r[WEIGHT_FRAC +: ACC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r && tag2_r.lastw;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag1_r <= seq_tag(cnt_r);
    end
    if (v1_r) begin
      tag2_r <= tag1_r;
      prod_r <= prod_nxt;
    end
    if (v2_r) begin
      // each row starts fresh at its translation word
      sum_r  <= tag2_r.first ? SUM_W'(addend) : sum_r + SUM_W'(addend);
      row3_r <= tag2_r.row;
    end
    if (v3_r) begin
      r_r    <= r_nxt;
      row4_r <= row3_r;
    end
    if (v4_r) begin
      wprod_r <= PROD_W'(r_r) * PROD_W'(signed'({1'b0, w_r}));
      row5_r  <= row4_r;
    end
  end

  // accumulate with saturation, cleared once the vertex is emitted
  always_comb begin
    unique case (row5_r)
      2'd0:    acc_sel = acc_x_r;
      2'd1:    acc_sel = acc_y_r;
      default: acc_sel = acc_z_r;
    endcase
    acc_sum = (ACC_W+1)'(acc_sel) + (ACC_W+1)'(term);
    if (acc_sum > (ACC_W+1)'(ACC_MAX)) begin
      acc_upd = ACC_MAX;
    end else if (acc_sum < (ACC_W+1)'(ACC_MIN)) begin
      acc_upd = ACC_MIN;
    end else begin
      acc_upd = ACC_W'(acc_sum);
    end
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    acc_z_nxt = acc_z_r;
    if (out_load) begin
      acc_x_nxt = '0;
      acc_y_nxt = '0;
      acc_z_nxt = '0;
    end else if (v5_r) begin
      unique case (row5_r)
        2'd0:    acc_x_nxt = acc_upd;
        2'd1:    acc_y_nxt = acc_upd;
        default: acc_z_nxt = acc_upd;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end else begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      acc_z_r <= acc_z_nxt;
    end
  end

  // output saturation to 32 bits, clipped flags it
  always_comb begin
    clip_x = (acc_x_r > ACC_W'(OUT_MAX)) || (acc_x_r < ACC_W'(OUT_MIN));
    clip_y = (acc_y_r > ACC_W'(OUT_MAX)) || (acc_y_r < ACC_W'(OUT_MIN));
    clip_z = (acc_z_r > ACC_W'(OUT_MAX)) || (acc_z_r < ACC_W'(OUT_MIN));
    sat_x  = clip_x ? (acc_x_r[ACC_W-1] ? OUT_MIN : OUT_MAX) : OUT_W'(acc_x_r);
    sat_y  = clip_y ? (acc_y_r[ACC_W-1] ? OUT_MIN : OUT_MAX) : OUT_W'(acc_y_r);
    sat_z  = clip_z ? (acc_z_r[ACC_W-1] ? OUT_MIN : OUT_MAX) : OUT_W'(acc_z_r);
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r   <= sat_x;
      out_y_r   <= sat_y;
      out_z_r   <= sat_z;
      clipped_r <= clip_x || clip_y || clip_z;
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.out_x   = out_x_r;
  assign out_res.out_y   = out_y_r;
  assign out_res.out_z   = out_z_r;
  assign out_res.clipped = clipped_r;

`ifndef NO_ASSERTIONS
  // a row finishes only after all four of its words are read, so the weighting stages never overlap
  a_row_tail_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({v3_r, v4_r, v5_r}))
    else $error("two rows in the weighting stages at once");

  // a vertex is emitted only once every term has landed
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !busy)
    else $error("vertex emitted with products still in flight");

  // store words only come back during a contribution
  a_pipe_in_contrib: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("store read data outside a contribution");

  // accumulators start from zero for the next vertex
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (acc_x_r == '0 && acc_y_r == '0 && acc_z_r == '0))
    else $error("accumulators not cleared after emit");
`endif

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for linear_blend_skinning: random and directed requests,
// a bit-exact blend predictor and an in-order result checker
// depends on lbs_pkg, lbs_in_if / lbs_out_if and the linear_blend_skinning top level
`timescale 1ns / 1ps

module tb_top;
  import lbs_pkg::*;

  localparam int  ITEM_TARGET  = 1400;
  localparam int  IDLE_LIMIT   = 3000;   // cycles with no handshake on either side
  localparam int  LONG_HOLD    = 400;    // receiver back-pressure stretch
  localparam int  DRAIN_CYCLES = 40;
  localparam int  STORE_WORDS  = DEF_MAX_BONES * WORDS_PER_BONE;
  localparam int  BONE_TOP     = DEF_MAX_BONES - 1;
  localparam int  ELEM_TOP     = (1 << ELEM_W) - 1;
  localparam int  WEIGHT_TOP   = (1 << WEIGHT_W) - 1;
  localparam int  ONE_Q16      = 32'h0001_0000;
  localparam int  POS_MAX      = 32'h7FFF_FFFF;
  localparam int  POS_MIN      = 32'h8000_0000;

  localparam longint ACC_HI = longint'(ACC_MAX);
  localparam longint ACC_LO = longint'(ACC_MIN);
  localparam longint OUT_HI = longint'(OUT_MAX);
  localparam longint OUT_LO = longint'(OUT_MIN);

  // one request as the sender sees it
  typedef struct {
    logic                     action;
    logic [BONE_W-1:0]        bone;
    logic [ELEM_W-1:0]        element;
    logic signed [WORD_W-1:0] word;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic [WEIGHT_W-1:0]      weight;
    logic                     last;
  } skin_req_t;

  // one blended vertex
  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    clipped;
  } vertex_t;

  // bit-exact blend predictor plus in-order vertex checker
  class skin_scoreboard;
    logic signed [WORD_W-1:0] xform_words [STORE_WORDS];
    longint                   acc_x;
    longint                   acc_y;
    longint                   acc_z;
    vertex_t                  pending_vertices [$];
    int                       failures;
    int                       mismatches;

    function new();
      foreach (xform_words[i]) xform_words[i] = '0;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      failures = 0;
      mismatches = 0;
    endfunction

    function longint limit_to(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // weight * (R[row] . p + t[row]), floor shifts, row sum clamped to 48 bits
    function longint row_term(int base, int row, longint px, longint py, longint pz,
                              longint w);
      longint r;
      r = longint'(xform_words[base + 9 + row]);
      r = r + ((longint'(xform_words[base + 3*row])     * px) >>> DEF_FRAC_BITS);
      r = r + ((longint'(xform_words[base + 3*row + 1]) * py) >>> DEF_FRAC_BITS);
      r = r + ((longint'(xform_words[base + 3*row + 2]) * pz) >>> DEF_FRAC_BITS);
      r = limit_to(r, ACC_LO, ACC_HI);
      return (r * w) >>> WEIGHT_FRAC;
    endfunction

    function void note_request(skin_req_t r);
      int      base;
      longint  w;
      longint  px;
      longint  py;
      longint  pz;
      longint  vx;
      longint  vy;
      longint  vz;
      vertex_t v;
      if (r.action == ACT_LOAD) begin
        // out-of-range element or bone is dropped, last flag means nothing here
        if (int'(r.bone) < DEF_MAX_BONES && int'(r.element) < WORDS_PER_BONE) begin
          xform_words[int'(r.bone) * WORDS_PER_BONE + int'(r.element)] = r.word;
        end
        return;
      end
      if (int'(r.bone) < DEF_MAX_BONES) begin
        base = int'(r.bone) * WORDS_PER_BONE;
        w = (r.weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(r.weight);
        px = longint'(r.pos_x);
        py = longint'(r.pos_y);
        pz = longint'(r.pos_z);
        acc_x = limit_to(acc_x + row_term(base, 0, px, py, pz, w), ACC_LO, ACC_HI);
        acc_y = limit_to(acc_y + row_term(base, 1, px, py, pz, w), ACC_LO, ACC_HI);
        acc_z = limit_to(acc_z + row_term(base, 2, px, py, pz, w), ACC_LO, ACC_HI);
      end
      if (r.last) begin
        vx = limit_to(acc_x, OUT_LO, OUT_HI);
        vy = limit_to(acc_y, OUT_LO, OUT_HI);
        vz = limit_to(acc_z, OUT_LO, OUT_HI);
        v.x = vx[OUT_W-1:0];
        v.y = vy[OUT_W-1:0];
        v.z = vz[OUT_W-1:0];
        // only output saturation raises the flag
        v.clipped = (vx != acc_x) || (vy != acc_y) || (vz != acc_z);
        pending_vertices.push_back(v);
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
      end
    endfunction

    function void check_result(vertex_t got);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected vertex x=%h y=%h z=%h clipped=%b",
                   got.x, got.y, got.z, got.clipped);
        end
        return;
      end
      want = pending_vertices.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.clipped !== want.clipped) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("vertex mismatch: expected x=%h y=%h z=%h clipped=%b",
                   want.x, want.y, want.z, want.clipped);
          $display("                 actual   x=%h y=%h z=%h clipped=%b",
                   got.x, got.y, got.z, got.clipped);
        end
      end
    endfunction

    function int pending();
      return pending_vertices.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lbs_in_if  in_req();
  lbs_out_if out_res();

  linear_blend_skinning i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  skin_scoreboard skin_sb = new();

  // stimulus-side bookkeeping: which store words have been loaded, so that a
  // contribution never touches a bone with unwritten words
  bit [WORDS_PER_BONE-1:0] bone_mask [DEF_MAX_BONES];
  bit                      bone_listed [DEF_MAX_BONES];
  int                      full_bones [$];

  int items_sent    = 0;
  bit quiet_phase   = 1'b0;   // no idling on either side while set
  bit hold_request  = 1'b0;   // asks the receiver for one long back-pressure stretch

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_phase || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // q16.16 coordinate, usually of moderate size, sometimes anywhere in range
  function automatic int rand_coord();
    int v;
    v = $urandom;
    if ($urandom_range(0, 4) != 0) v = v >>> $urandom_range(4, 14);
    return v;
  endfunction

  // rotation words near +-4.0, translations near +-2^9, or fully random words
  function automatic int rand_xform(int elem, bit wild);
    int v;
    v = $urandom;
    if (!wild) v = (elem >= 9) ? (v >>> 6) : (v >>> 13);
    return v;
  endfunction

  // drive one request and hold it until the block takes it
  task automatic send_req(input skin_req_t r);
    int gap;
    in_req.valid   <= 1'b1;
    in_req.action  <= r.action;
    in_req.bone    <= r.bone;
    in_req.element <= r.element;
    in_req.word    <= r.word;
    in_req.pos_x   <= r.pos_x;
    in_req.pos_y   <= r.pos_y;
    in_req.pos_z   <= r.pos_z;
    in_req.weight  <= r.weight;
    in_req.last    <= r.last;
    do @(posedge clk); while (!in_req.ready);
    skin_sb.note_request(r);
    // loads to elements 12-15 are dropped by the block and do not count
    if (!(r.action == ACT_LOAD && int'(r.element) >= WORDS_PER_BONE)) items_sent++;
    gap = idle_span();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_word(input int b, input int e, input int w, input bit lst);
    skin_req_t r;
    r.action  = ACT_LOAD;
    r.bone    = BONE_W'(b);
    r.element = ELEM_W'(e);
    r.word    = w;
    r.pos_x   = rand_coord();
    r.pos_y   = rand_coord();
    r.pos_z   = rand_coord();
    r.weight  = WEIGHT_W'($urandom_range(0, WEIGHT_TOP));
    r.last    = lst;
    if (e < WORDS_PER_BONE) begin
      bone_mask[b][e] = 1'b1;
      if (&bone_mask[b] && !bone_listed[b]) begin
        bone_listed[b] = 1'b1;
        full_bones.push_back(b);
      end
    end
    send_req(r);
  endtask

  task automatic contribute(input int b, input int px, input int py, input int pz,
                            input int w, input bit lst);
    skin_req_t r;
    r.action  = ACT_CONTRIB;
    r.bone    = BONE_W'(b);
    r.element = ELEM_W'($urandom_range(0, ELEM_TOP));   // ignored on contributions
    r.word    = $urandom;
    r.pos_x   = px;
    r.pos_y   = py;
    r.pos_z   = pz;
    r.weight  = WEIGHT_W'(w);
    r.last    = lst;
    send_req(r);
  endtask

  // rewrite all 12 words of one bone
  task automatic load_bone(input int b, input bit wild);
    int e;
    for (e = 0; e < WORDS_PER_BONE; e++) begin
      load_word(b, e, rand_xform(e, wild), 1'($urandom_range(0, 1)));
    end
  endtask

  // one vertex: a few contributions from loaded bones, last flag on the final one
  task automatic blend_vertex();
    int n;
    int i;
    int b;
    int w;
    int rest;
    int px;
    int py;
    int pz;
    bit share;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    share = ($urandom_range(0, 9) != 0);
    rest = ONE_Q16;
    px = rand_coord();
    py = rand_coord();
    pz = rand_coord();
    for (i = 0; i < n; i++) begin
      if (!share) begin
        px = rand_coord();
        py = rand_coord();
        pz = rand_coord();
      end
      b = full_bones[$urandom_range(0, full_bones.size() - 1)];
      // usually weights that sum to one, sometimes anything up to the field limit
      if ($urandom_range(0, 6) == 0) w = $urandom_range(0, WEIGHT_TOP);
      else if (i == n - 1) w = rest;
      else w = $urandom_range(0, rest);
      rest = (w > rest) ? 0 : rest - w;
      contribute(b, px, py, pz, w, i == n - 1);
    end
  endtask

  // sender pause: let every expected vertex come out before going on
  task automatic wait_drained();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (skin_sb.pending() != 0);
  endtask

  // request side and end of run
  initial begin
    int  e;
    int  pick;
    bit  held;
    bit  drained;
    rst_n          <= 1'b0;
    in_req.valid   <= 1'b0;
    in_req.action  <= ACT_LOAD;
    in_req.bone    <= '0;
    in_req.element <= '0;
    in_req.word    <= '0;
    in_req.pos_x   <= '0;
    in_req.pos_y   <= '0;
    in_req.pos_z   <= '0;
    in_req.weight  <= '0;
    in_req.last    <= 1'b0;
    held    = 1'b0;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bone 0 is the identity with no translation, bone 63 holds extreme words
    for (e = 0; e < WORDS_PER_BONE; e++) begin
      load_word(0, e, (e == 0 || e == 4 || e == 8) ? ONE_Q16 : 0, 1'b0);
    end
    for (e = 0; e < WORDS_PER_BONE; e++) begin
      load_word(BONE_TOP, e, e[0] ? POS_MIN : POS_MAX, 1'b0);
    end

    // identity passes the position through untouched, even at the range limits
    contribute(0, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000, ONE_Q16, 1'b1);
    contribute(0, POS_MAX, POS_MIN, 0, ONE_Q16, 1'b1);
    // zero weight, and a weight above one that must saturate to one
    contribute(0, rand_coord(), rand_coord(), rand_coord(), 0, 1'b1);
    contribute(0, rand_coord(), rand_coord(), rand_coord(), WEIGHT_TOP, 1'b1);
    // extreme transform at full weight drives every output into saturation; then the same bone at the smallest weight
    contribute(BONE_TOP, POS_MAX, POS_MAX, POS_MAX, ONE_Q16, 1'b1);
    contribute(BONE_TOP, POS_MIN, POS_MIN, POS_MIN, 1, 1'b1);
    // repeated huge terms pin the accumulators at their 48-bit limits
    repeat (3) contribute(BONE_TOP, POS_MAX, POS_MIN, POS_MAX, ONE_Q16, 1'b0);
    contribute(BONE_TOP, POS_MAX, POS_MIN, POS_MAX, ONE_Q16, 1'b1);
    // load carrying a last flag still just writes the word, no vertex comes out
    load_word(0, 9, ONE_Q16, 1'b1);
    contribute(0, 0, 0, 0, ONE_Q16, 1'b1);
    // loads to elements past the translation are dropped
    load_word(5, 15, $urandom, 1'b0);
    load_word(BONE_TOP, 12, 0, 1'b1);
    contribute(BONE_TOP, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, ONE_Q16, 1'b1);
    // split weights across two bones, last flag only on the second
    contribute(0, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 32'h0000_8000, 1'b0);
    contribute(BONE_TOP, 32'h0000_0100, 32'hFFFF_FF00, 0, 32'h0000_8000, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      if (!held && items_sent >= 400) begin
        held = 1'b1;
        hold_request = 1'b1;
      end
      if (!drained && items_sent >= 800) begin
        drained = 1'b1;
        wait_drained();
      end
      quiet_phase = (items_sent >= 1000 && items_sent < 1150);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        load_bone($urandom_range(0, BONE_TOP), $urandom_range(0, 5) == 0);
      end else if (pick < 14) begin
        e = $urandom_range(0, WORDS_PER_BONE - 1);
        load_word($urandom_range(0, BONE_TOP), e, rand_xform(e, $urandom_range(0, 3) == 0),
                  1'($urandom_range(0, 1)));
      end else if (pick < 17) begin
        load_word($urandom_range(0, BONE_TOP), $urandom_range(WORDS_PER_BONE, ELEM_TOP),
                  $urandom, 1'($urandom_range(0, 1)));
      end else begin
        blend_vertex();
      end
    end
    quiet_phase = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (skin_sb.failures == 0 && skin_sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side: random back-pressure, one long hold on request, check on accept
  initial begin
    int stall_left;
    stall_left = 0;
    out_res.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_res.valid && out_res.ready) begin
        skin_sb.check_result('{out_res.out_x, out_res.out_y, out_res.out_z,
                               out_res.clipped});
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_res.ready <= 1'b0;
        stall_left--;
      end else begin
        out_res.ready <= 1'b1;
        stall_left = idle_span();
      end
    end
  end

  // watchdog: too long without any handshake means the block is stuck
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
